// ===== sv/pti_pkg.sv =====
// Package for the phase-to-PWM interpolator: word types, register indexes,
// phase/voltage point tables. No dependencies.
`default_nettype none
package pti_pkg;
  localparam int TABLE_HELD = 54;
  localparam logic [23:0] PWM_SCALE_RESET = 24'd836147;
  localparam logic [12:0] VOLTAGE_LIMIT_RESET = 13'd4787;
  localparam logic [0:0] REG_PWM_SCALE = 1'b0;
  localparam logic [0:0] REG_VOLTAGE_LIMIT = 1'b1;
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_LOW = 2'd1;
  localparam logic [1:0] CLAMP_HIGH = 2'd2;

  typedef struct packed {
    logic [15:0] duty_count;
    logic [12:0] voltage_q;
    logic [1:0]  table_clamp;
  } out_word_t;

  typedef struct packed {
    logic        load;
    logic        scan_step;
    logic        div_start;
    logic        finish;
  } pti_cmd_t;

  typedef struct packed {
    logic        scan_hit;
    logic        scan_end;
    logic        div_done;
    logic        direct;
  } pti_sts_t;

  function automatic logic signed [15:0] phase_pt(input logic [5:0] i);
    logic signed [15:0] p;
    case (i)
      6'd0: p = -16'sd21055;  6'd1: p = -16'sd20755;  6'd2: p = -16'sd20650;
      6'd3: p = -16'sd20308;  6'd4: p = -16'sd20093;  6'd5: p = -16'sd19720;
      6'd6: p = -16'sd19231;  6'd7: p = -16'sd18279;  6'd8: p = -16'sd16098;
      6'd9: p = -16'sd15944;  6'd10: p = -16'sd15432; 6'd11: p = -16'sd14044;
      6'd12: p = -16'sd12954; 6'd13: p = -16'sd10200; 6'd14: p = -16'sd7385;
      6'd15: p = -16'sd454;   6'd16: p = 16'sd5868;   6'd17: p = 16'sd7247;
      6'd18: p = 16'sd10837;  6'd19: p = 16'sd12569;  6'd20: p = 16'sd14164;
      6'd21: p = 16'sd15140;  6'd22: p = 16'sd16465;  6'd23: p = 16'sd16880;
      6'd24: p = 16'sd17581;  6'd25: p = 16'sd17784;  6'd26: p = 16'sd18471;
      6'd27: p = 16'sd18748;  6'd28: p = 16'sd19061;  6'd29: p = 16'sd19189;
      6'd30: p = 16'sd19444;  6'd31: p = 16'sd19536;  6'd32: p = 16'sd19728;
      6'd33: p = 16'sd19807;  6'd34: p = 16'sd19993;  6'd35: p = 16'sd20030;
      6'd36: p = 16'sd20173;  6'd37: p = 16'sd20226;  6'd38: p = 16'sd20332;
      6'd39: p = 16'sd20419;  6'd40: p = 16'sd20446;  6'd41: p = 16'sd20615;
      6'd42: p = 16'sd20639;  6'd43: p = 16'sd20744;  6'd44: p = 16'sd20787;
      6'd45: p = 16'sd20820;  6'd46: p = 16'sd20908;  6'd47: p = 16'sd20930;
      6'd48: p = 16'sd20995;  6'd49: p = 16'sd21027;  6'd50: p = 16'sd21005;
      6'd51: p = 16'sd21034;  6'd52: p = 16'sd21040;  6'd53: p = 16'sd21055;
      default: p = 16'sd21055;
    endcase
    return p;
  endfunction

  function automatic logic [12:0] volt_pt(input logic [5:0] i);
    logic [12:0] v;
    case (i)
      6'd0: v = 13'd0;     6'd1: v = 13'd256;   6'd2: v = 13'd512;
      6'd3: v = 13'd768;   6'd4: v = 13'd1024;  6'd5: v = 13'd1280;
      6'd6: v = 13'd1536;  6'd7: v = 13'd1792;  6'd8: v = 13'd2048;
      6'd9: v = 13'd2074;  6'd10: v = 13'd2099; 6'd11: v = 13'd2176;
      6'd12: v = 13'd2227; 6'd13: v = 13'd2304; 6'd14: v = 13'd2355;
      6'd15: v = 13'd2432; 6'd16: v = 13'd2483; 6'd17: v = 13'd2509;
      6'd18: v = 13'd2560; 6'd19: v = 13'd2611; 6'd20: v = 13'd2688;
      6'd21: v = 13'd2739; 6'd22: v = 13'd2816; 6'd23: v = 13'd2867;
      6'd24: v = 13'd2944; 6'd25: v = 13'd2995; 6'd26: v = 13'd3072;
      6'd27: v = 13'd3123; 6'd28: v = 13'd3200; 6'd29: v = 13'd3251;
      6'd30: v = 13'd3328; 6'd31: v = 13'd3379; 6'd32: v = 13'd3456;
      6'd33: v = 13'd3507; 6'd34: v = 13'd3584; 6'd35: v = 13'd3635;
      6'd36: v = 13'd3712; 6'd37: v = 13'd3763; 6'd38: v = 13'd3840;
      6'd39: v = 13'd3891; 6'd40: v = 13'd3968; 6'd41: v = 13'd4019;
      6'd42: v = 13'd4096; 6'd43: v = 13'd4147; 6'd44: v = 13'd4224;
      6'd45: v = 13'd4275; 6'd46: v = 13'd4352; 6'd47: v = 13'd4403;
      6'd48: v = 13'd4480; 6'd49: v = 13'd4531; 6'd50: v = 13'd4608;
      6'd51: v = 13'd4659; 6'd52: v = 13'd4736; 6'd53: v = 13'd4787;
      default: v = 13'd4787;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== sv/pti_if.sv =====
// Valid/ready channel interface with parameterized payload type.
// Depends on nothing.
`default_nettype none
interface pti_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pti_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on nothing.
`default_nettype none
interface pti_cfg_if (input wire logic clk);
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/phase_to_pwm_interpolator.sv =====
// Phase-to-PWM interpolator top level: registers, controller, datapath.
// Each word is checked for clamping, then scanned for its interval and, when
// one matches with rising phase points, divided; other words skip the divide.
// One word at a time; the next is taken the cycle after the result is
// registered, and no result is registered while the last one waits.
// Synchronous active-low reset restores register defaults and empties output.
`default_nettype none
module phase_to_pwm_interpolator
  import pti_pkg::*;
#(
  parameter int TABLE_ENTRIES = 54
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pti_if.sink       in_ch,
  pti_if.source     out_ch,
  pti_cfg_if.sink   cfg_ch
);
  localparam int NPTS = (TABLE_ENTRIES < 2) ? 2 :
                        (TABLE_ENTRIES > TABLE_HELD) ? TABLE_HELD : TABLE_ENTRIES;
  logic [23:0] scale_r;
  logic [12:0] limit_r;
  pti_cmd_t    cmd;
  pti_sts_t    sts;
  out_word_t   res;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= PWM_SCALE_RESET;
      limit_r <= VOLTAGE_LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_PWM_SCALE) scale_r <= cfg_ch.wdata;
      else limit_r <= cfg_ch.wdata[12:0];
    end
  end

  pti_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  pti_datapath #(.NPTS(NPTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .phase_in(in_ch.data),
    .pwm_scale(scale_r), .voltage_limit(limit_r), .result(res)
  );
  assign out_ch.data = res;
endmodule
`default_nettype wire

// ===== sv/pti_div.sv =====
// Serial restoring divider, one quotient bit per cycle, rounds half away.
// Unsigned magnitudes; depends on nothing.
`default_nettype none
module pti_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [27:0] num,
  input  wire logic [15:0] den,
  output logic             done,
  output logic [27:0]      quot
);
  logic [27:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[15:0], q_r[27]};
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = num + 28'({1'b0, den[15:1]});
      rem_nxt = '0;
      cnt_nxt = 5'd27;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt = {q_r[26:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[26:0], 1'b0};
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end
  // done is high the cycle the final quotient sits in q_r
  assign done = done_r;
  assign quot = q_r;
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/pti_datapath.sv =====
// Datapath: point scan, interpolation, clamp and PWM scaling registers.
// Depends on pti_pkg and pti_div.
`default_nettype none
module pti_datapath
  import pti_pkg::*;
#(
  parameter int NPTS = 54
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  pti_cmd_t         cmd,
  output pti_sts_t         sts,
  input  wire logic [15:0] phase_in,
  input  wire logic [23:0] pwm_scale,
  input  wire logic [12:0] voltage_limit,
  output out_word_t        result
);
  logic signed [15:0] x_r;
  logic [5:0]         idx_r, idx_nxt;
  logic [1:0]         clamp_r;
  logic signed [14:0] vbase_r;
  logic               neg_r;
  logic signed [15:0] p0, p1;
  logic signed [16:0] dx, den;
  logic signed [13:0] dv;
  logic signed [30:0] prod;
  logic [27:0]        mag;
  logic               div_done;
  logic [27:0]        quot;
  logic signed [29:0] vsum;
  logic [12:0]        vq;
  logic [36:0]        pwm_full;
  logic [5:0]         last;

  assign last = 6'(NPTS - 1);
  assign p0 = phase_pt(idx_r);
  assign p1 = phase_pt(idx_r + 6'd1);
  assign dx = 17'(x_r) - 17'(p0);
  assign den = 17'(p1) - 17'(p0);
  assign dv = 14'(volt_pt(idx_r + 6'd1)) - 14'(volt_pt(idx_r));
  assign prod = 31'(dx) * 31'(dv);
  assign mag = prod[30] ? 28'(-prod) : 28'(prod);

  assign sts.scan_hit = (x_r >= p0) && (x_r <= p1);
  assign sts.scan_end = (idx_r + 6'd1 >= last);
  assign sts.div_done = div_done;
  assign sts.direct = (clamp_r != CLAMP_NONE) || (den <= 17'sd0) || !sts.scan_hit;

  pti_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(mag), .den(den[15:0]), .done(div_done), .quot(quot)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) idx_nxt = '0;
    else if (cmd.scan_step) idx_nxt = idx_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      x_r <= phase_in;
      if ($signed(phase_in) <= phase_pt(6'd0)) begin
        clamp_r <= CLAMP_LOW;
        vbase_r <= 15'(volt_pt(6'd0));
      end else if ($signed(phase_in) >= phase_pt(last)) begin
        clamp_r <= CLAMP_HIGH;
        vbase_r <= 15'(volt_pt(last));
      end else begin
        clamp_r <= CLAMP_NONE;
        vbase_r <= 15'(volt_pt(last));
      end
    end
    if (cmd.div_start) begin
      neg_r <= prod[30];
      vbase_r <= 15'(volt_pt(idx_r));
    end else if (cmd.scan_step && sts.scan_hit && clamp_r == CLAMP_NONE) begin
      vbase_r <= 15'(volt_pt(idx_r));
      neg_r <= 1'b0;
    end
  end

  logic signed [29:0] qs_r;
  logic               use_q_r;
  always_ff @(posedge clk) begin
    if (cmd.load) use_q_r <= 1'b0;
    else if (div_done) begin
      use_q_r <= 1'b1;
      qs_r <= neg_r ? -30'(quot) : 30'(quot);
    end
  end

  assign vsum = 30'(vbase_r) + (use_q_r ? qs_r : 30'sd0);
  always_comb begin
    if (vsum < 30'sd0) vq = '0;
    else if (vsum > 30'(voltage_limit)) vq = voltage_limit;
    else vq = vsum[12:0];
  end
  assign pwm_full = 37'(vq) * 37'(pwm_scale);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.voltage_q <= vq;
      result.table_clamp <= clamp_r;
      result.duty_count <= (pwm_full[36:16] > 21'd65535) ? 16'hFFFF : pwm_full[31:16];
    end
  end
endmodule
`default_nettype wire

// ===== sv/pti_ctrl.sv =====
// Controller: handshakes and sequencing of scan, divide and finish.
// Depends on pti_pkg.
`default_nettype none
module pti_ctrl
  import pti_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  pti_sts_t  sts,
  output pti_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_CHECK = 6'b000010, S_SCAN = 6'b000100,
    S_DIV = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
  } state_t;
  state_t st_r, st_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    st_nxt = st_r;
    ov_nxt = ov_r;
    cmd = '0;
    in_ready = (st_r == S_IDLE);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        st_nxt = S_CHECK;
      end
      S_CHECK: begin
        st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.direct && !sts.scan_hit) begin
          if (sts.scan_end || sts.direct && !sts.scan_hit && 1'b0) st_nxt = S_FIN;
          else cmd.scan_step = 1'b1;
        end else if (sts.direct) begin
          cmd.scan_step = sts.scan_hit;
          st_nxt = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          st_nxt = S_DIV;
        end
      end
      S_DIV: if (sts.div_done) st_nxt = S_FIN;
      S_FIN: if (!ov_r || out_ready) begin
        cmd.finish = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/pti_checker.sv =====
// Port-level checker for the phase-to-PWM interpolator, bound to the top.
// Depends on pti_pkg.
`default_nettype none
module pti_checker
  import pti_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.table_clamp <= CLAMP_HIGH) else $error("clamp code");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("one at a time");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
endmodule
bind phase_to_pwm_interpolator pti_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== test/phase_to_pwm_interpolator_test.sv =====
// Testbench for the phase-to-PWM interpolator: drives phase words, predicts
// table interpolation, clamp and PWM scaling, and checks each result word.
// Depends on pti_pkg, pti_if, pti_cfg_if and phase_to_pwm_interpolator.
module phase_to_pwm_interpolator_test;
  import pti_pkg::*;

  localparam int N_PTS = 54;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  pti_if #(.T(logic [15:0])) in_ch (clk);
  pti_if #(.T(out_word_t)) out_ch (clk);
  pti_cfg_if cfg_ch (clk);

  phase_to_pwm_interpolator #(.TABLE_ENTRIES(54)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  int pts_phase [N_PTS] = '{
    -21055, -20755, -20650, -20308, -20093, -19720, -19231, -18279, -16098,
    -15944, -15432, -14044, -12954, -10200, -7385, -454, 5868, 7247,
    10837, 12569, 14164, 15140, 16465, 16880, 17581, 17784, 18471,
    18748, 19061, 19189, 19444, 19536, 19728, 19807, 19993, 20030,
    20173, 20226, 20332, 20419, 20446, 20615, 20639, 20744, 20787,
    20820, 20908, 20930, 20995, 21027, 21005, 21034, 21040, 21055};
  int pts_volt [N_PTS] = '{
    0, 256, 512, 768, 1024, 1280, 1536, 1792, 2048,
    2074, 2099, 2176, 2227, 2304, 2355, 2432, 2483, 2509,
    2560, 2611, 2688, 2739, 2816, 2867, 2944, 2995, 3072,
    3123, 3200, 3251, 3328, 3379, 3456, 3507, 3584, 3635,
    3712, 3763, 3840, 3891, 3968, 4019, 4096, 4147, 4224,
    4275, 4352, 4403, 4480, 4531, 4608, 4659, 4736, 4787};

  logic [23:0] scale_q8;
  logic [12:0] volt_limit;
  logic [15:0] phase_queue[$];
  out_word_t   pwm_expected[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_recv = 0;
  bit send_pause = 0;
  bit in_fire = 0;

  function automatic out_word_t predict_pwm(logic [15:0] raw);
    out_word_t r;
    int x, v, i;
    longint num, den, mag, q, pwm;
    logic [1:0] clamp;
    x = $signed(raw);
    v = pts_volt[N_PTS-1];
    clamp = CLAMP_NONE;
    if (x <= pts_phase[0]) begin
      v = pts_volt[0];
      clamp = CLAMP_LOW;
    end else if (x >= pts_phase[N_PTS-1]) begin
      clamp = CLAMP_HIGH;
    end else begin
      for (i = 0; i < N_PTS - 1; i++) begin
        if (x >= pts_phase[i] && x <= pts_phase[i+1]) begin
          den = pts_phase[i+1] - pts_phase[i];
          if (den <= 0) v = pts_volt[i];
          else begin
            num = longint'(x - pts_phase[i]) * (pts_volt[i+1] - pts_volt[i]);
            mag = num < 0 ? -num : num;
            q = (mag + den / 2) / den;
            v = pts_volt[i] + int'(num < 0 ? -q : q);
          end
          break;
        end
      end
    end
    if (v < 0) v = 0;
    if (v > volt_limit) v = volt_limit;
    pwm = (longint'(v) * scale_q8) >>> 16;
    if (pwm > 65535) pwm = 65535;
    r.duty_count = pwm[15:0];
    r.voltage_q = v[12:0];
    r.table_clamp = clamp;
    return r;
  endfunction

  // driver; in_fire marks the word taken at the last rising edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_fire) void'(phase_queue.pop_front());
      if (phase_queue.size() != 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= phase_queue[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // the pop above happens before indexing, so phase_queue[0] is the next word
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      pwm_expected.push_back(predict_pwm(in_ch.data));
  end

  always @(negedge clk) begin
    if (hold_recv > 0) begin
      hold_recv <= hold_recv - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pwm_expected.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_ch.data);
        errors <= errors + 1;
      end else begin
        if (out_ch.data.duty_count !== pwm_expected[0].duty_count)
          $display("%0t: duty_count exp %0d got %0d", $time,
                   pwm_expected[0].duty_count, out_ch.data.duty_count);
        if (out_ch.data.voltage_q !== pwm_expected[0].voltage_q)
          $display("%0t: voltage_q exp %0d got %0d", $time,
                   pwm_expected[0].voltage_q, out_ch.data.voltage_q);
        if (out_ch.data.table_clamp !== pwm_expected[0].table_clamp)
          $display("%0t: table_clamp exp %0d got %0d", $time,
                   pwm_expected[0].table_clamp, out_ch.data.table_clamp);
        if (out_ch.data !== pwm_expected[0]) errors <= errors + 1;
        void'(pwm_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    while (phase_queue.size() != 0 || in_ch.valid || pwm_expected.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_PWM_SCALE) scale_q8 = val;
    else volt_limit = val[12:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_phase();
    int k, sel;
    sel = $urandom_range(9);
    if (sel < 2) return 16'($urandom);
    if (sel < 4) return 16'($urandom_range(46080) - 23040);
    k = $urandom_range(N_PTS - 2);
    return 16'(pts_phase[k] + $urandom_range(600) - 300);
  endfunction

  initial begin
    int i, ph;
    logic [15:0] directed[$];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PWM_SCALE;
    cfg_ch.wdata = '0;
    scale_q8 = PWM_SCALE_RESET;
    volt_limit = VOLTAGE_LIMIT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000, -16'sd23040, 16'sd23040,
                 -16'sd21055, -16'sd21054, 16'sd21055, 16'sd21054, 16'sd21027,
                 16'sd21010, 16'sd21005, 16'sd21030, -16'sd454, 16'sd5868,
                 16'sd20000, -16'sd16000, 16'sd100};
    foreach (directed[j]) phase_queue.push_back(directed[j]);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_PWM_SCALE, 24'hffffff); write_reg(REG_VOLTAGE_LIMIT, 24'd8191); end
        1: begin write_reg(REG_PWM_SCALE, 24'd0); write_reg(REG_VOLTAGE_LIMIT, 24'd0); end
        2: begin write_reg(REG_PWM_SCALE, 24'd836147); write_reg(REG_VOLTAGE_LIMIT, 24'd3000); end
        3: begin write_reg(REG_PWM_SCALE, 24'($urandom)); write_reg(REG_VOLTAGE_LIMIT, 24'($urandom_range(8191))); end
        default: begin write_reg(REG_PWM_SCALE, 24'd400000); write_reg(REG_VOLTAGE_LIMIT, 24'd4787); end
      endcase
      send_idle_pct = (ph == 1 || ph == 3) ? 68 : (ph == 4 ? 26 : 0);
      recv_stall_pct = (ph == 2 || ph == 3) ? 68 : (ph == 4 ? 26 : 0);
      if (ph == 2) hold_recv = 600;
      for (i = 0; i < 190; i++) phase_queue.push_back(rand_phase());
      if (ph == 0) begin
        while (phase_queue.size() > 95) @(posedge clk);
        send_pause = 1;
        while (in_ch.valid || pwm_expected.size() != 0) @(posedge clk);
        send_pause = 0;
      end
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
